/* hdl/sbsc_pkg.sv */
package sbsc_pkg;

  // Default number of fractional bits of the fixed-point format.
  localparam int FRAC_BITS_DEF = 16;

  // Field widths fixed by the interface.
  localparam int VAL_W      = 32;
  localparam int SIZE_W     = 31;
  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 31;

  // Extents and numerators: a 32-bit offset plus two 32-bit components,
  // and the box size minus such a sum, both fit in 35 signed bits.
  localparam int NUM_W = 35;

  // Configuration register indexes.
  localparam logic [CFG_IDX_W-1:0] REG_SIZE_X = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_SIZE_Y = 2'd1;
  localparam logic [CFG_IDX_W-1:0] REG_SIZE_Z = 2'd2;

  // Operation codes.
  localparam logic [1:0] OP_LINE   = 2'd0;
  localparam logic [1:0] OP_SWEEP1 = 2'd1;
  localparam logic [1:0] OP_SWEEP2 = 2'd2;
  localparam logic [1:0] OP_NONE   = 2'd3;

  // Axis codes.
  localparam logic [1:0] AXIS_X    = 2'd0;
  localparam logic [1:0] AXIS_Y    = 2'd1;
  localparam logic [1:0] AXIS_Z    = 2'd2;
  localparam logic [1:0] AXIS_NONE = 2'd3;

  typedef struct packed {
    logic [1:0]              op;
    logic [1:0]              axis;
    logic signed [VAL_W-1:0] axis_offset;
    logic signed [VAL_W-1:0] dir_x;
    logic signed [VAL_W-1:0] dir_y;
    logic signed [VAL_W-1:0] dir_z;
    logic signed [VAL_W-1:0] init_from;
    logic signed [VAL_W-1:0] init_to;
    logic                    lower_closed;
    logic                    upper_closed;
  } item_t;

  typedef struct packed {
    logic                    hit;
    logic signed [VAL_W-1:0] from_factor;
    logic signed [VAL_W-1:0] to_factor;
  } result_t;

  // Controller to datapath.
  typedef struct packed {
    logic load;       // latch the incoming item
    logic prep;       // form numerators, handle a zero direction
    logic div_start;  // launch a division
    logic div_sel_b;  // divide the far-boundary numerator
    logic cap_a;      // keep the first quotient
    logic update;     // narrow the running interval
    logic emit;       // load the result register
  } ctrl_cmd_t;

  // Datapath to controller.
  typedef struct packed {
    logic skip;       // unused op or axis code
    logic dead;       // query already killed
    logic d_zero;     // moving direction is zero
    logic last;       // item closes the query
    logic div_done;   // divider result ready
  } dp_stat_t;

endpackage

/* hdl/sbsc_if.sv */
interface sbsc_item_if;
  logic               valid;
  logic               ready;
  logic [1:0]         op;
  logic [1:0]         axis;
  logic signed [31:0] axis_offset;
  logic signed [31:0] dir_x;
  logic signed [31:0] dir_y;
  logic signed [31:0] dir_z;
  logic signed [31:0] init_from;
  logic signed [31:0] init_to;
  logic               lower_closed;
  logic               upper_closed;

  modport source (
    output valid, op, axis, axis_offset, dir_x, dir_y, dir_z, init_from, init_to,
           lower_closed, upper_closed,
    input  ready
  );
  modport sink (
    input  valid, op, axis, axis_offset, dir_x, dir_y, dir_z, init_from, init_to,
           lower_closed, upper_closed,
    output ready
  );
endinterface

interface sbsc_result_if;
  logic               valid;
  logic               ready;
  logic               hit;
  logic signed [31:0] from_factor;
  logic signed [31:0] to_factor;

  modport source (
    output valid, hit, from_factor, to_factor,
    input  ready
  );
  modport sink (
    input  valid, hit, from_factor, to_factor,
    output ready
  );
endinterface

/* hdl/sbsc_div.sv */
module sbsc_div #(
  parameter int FRAC_BITS = sbsc_pkg::FRAC_BITS_DEF
) (
  input  logic                                clk,
  input  logic                                rst,
  input  logic                                start,
  input  logic signed [sbsc_pkg::NUM_W-1:0]   num,
  input  logic signed [sbsc_pkg::VAL_W-1:0]   den,
  output logic                                done,
  output logic signed [sbsc_pkg::VAL_W-1:0]   quot
);
  import sbsc_pkg::*;

  // Magnitude of the numerator, scaled by the fraction, shifted out MSB first.
  localparam int DVD_W = NUM_W - 1 + FRAC_BITS;
  localparam int CNT_W = $clog2(DVD_W + 1);
  localparam logic [VAL_W:0] POS_LIM = {2'b00, {(VAL_W-1){1'b1}}};
  localparam logic [VAL_W:0] NEG_LIM = {2'b01, {(VAL_W-1){1'b0}}};

  logic [DVD_W-1:0] dvd;
  logic [VAL_W-1:0] rem;
  logic [VAL_W-1:0] dmag;
  logic [VAL_W:0]   qacc;
  logic             ovf;
  logic             neg;
  logic             busy;
  logic [CNT_W-1:0] cnt;

  logic [NUM_W-1:0] nmag;
  logic [VAL_W:0]   trial;
  logic             ge;
  logic [VAL_W-1:0] sat;

  always_comb begin
    nmag  = num[NUM_W-1] ? NUM_W'(-num) : NUM_W'(num);
    trial = {rem, dvd[DVD_W-1]};
    ge    = trial >= {1'b0, dmag};
    if (neg) begin
      if (ovf || qacc > NEG_LIM) begin
        sat = {1'b1, {(VAL_W-1){1'b0}}};
      end else begin
        sat = VAL_W'({1'b0, {VAL_W{1'b0}}} - qacc);
      end
    end else begin
      if (ovf || qacc > POS_LIM) begin
        sat = {1'b0, {(VAL_W-1){1'b1}}};
      end else begin
        sat = qacc[VAL_W-1:0];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      cnt  <= '0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy <= 1'b1;
        cnt  <= CNT_W'(DVD_W);
      end else if (busy) begin
        if (cnt != '0) begin
          cnt <= cnt - CNT_W'(1);
        end else begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      dvd  <= {nmag[NUM_W-2:0], {FRAC_BITS{1'b0}}};
      dmag <= den[VAL_W-1] ? VAL_W'(-den) : VAL_W'(den);
      neg  <= num[NUM_W-1] ^ den[VAL_W-1];
      rem  <= '0;
      qacc <= '0;
      ovf  <= 1'b0;
    end else if (busy) begin
      if (cnt != '0) begin
        dvd  <= {dvd[DVD_W-2:0], 1'b0};
        rem  <= ge ? VAL_W'(trial - {1'b0, dmag}) : trial[VAL_W-1:0];
        qacc <= {qacc[VAL_W-1:0], ge};
        ovf  <= ovf | qacc[VAL_W];
      end else begin
        quot <= sat;
      end
    end
  end

endmodule

/* hdl/sbsc_dp.sv */
module sbsc_dp #(
  parameter int FRAC_BITS = sbsc_pkg::FRAC_BITS_DEF
) (
  input  logic                                clk,
  input  logic                                rst,
  input  sbsc_pkg::ctrl_cmd_t                 cmd,
  output sbsc_pkg::dp_stat_t                  stat,
  input  sbsc_pkg::item_t                     item_in,
  output sbsc_pkg::result_t                   res,
  input  logic                                cfg_wr_en,
  input  logic [sbsc_pkg::CFG_IDX_W-1:0]      cfg_index,
  input  logic [sbsc_pkg::CFG_DATA_W-1:0]     cfg_data
);
  import sbsc_pkg::*;

  logic [SIZE_W-1:0] size_x;
  logic [SIZE_W-1:0] size_y;
  logic [SIZE_W-1:0] size_z;

  item_t                   cur;
  logic signed [VAL_W-1:0] running_from;
  logic signed [VAL_W-1:0] running_to;
  logic                    query_dead;
  logic signed [NUM_W-1:0] num_a;
  logic signed [NUM_W-1:0] num_b;
  logic signed [VAL_W-1:0] d_r;
  logic signed [VAL_W-1:0] qa;

  logic signed [NUM_W-1:0] off_e;
  logic signed [NUM_W-1:0] dx_e;
  logic signed [NUM_W-1:0] dy_e;
  logic signed [NUM_W-1:0] lo;
  logic signed [NUM_W-1:0] hi;
  logic signed [NUM_W-1:0] size_e;
  logic signed [VAL_W-1:0] d_sel;
  logic                    kill;
  logic signed [VAL_W-1:0] quot;
  logic signed [VAL_W-1:0] qf;
  logic signed [VAL_W-1:0] qt;

  sbsc_div #(.FRAC_BITS(FRAC_BITS)) u_div (
    .clk   (clk),
    .rst   (rst),
    .start (cmd.div_start),
    .num   (cmd.div_sel_b ? num_b : num_a),
    .den   (d_r),
    .done  (stat.div_done),
    .quot  (quot)
  );

  // Extents of the swept shape on the current axis.
  always_comb begin
    off_e = {{(NUM_W-VAL_W){cur.axis_offset[VAL_W-1]}}, cur.axis_offset};
    dx_e  = {{(NUM_W-VAL_W){cur.dir_x[VAL_W-1]}}, cur.dir_x};
    dy_e  = {{(NUM_W-VAL_W){cur.dir_y[VAL_W-1]}}, cur.dir_y};
    lo    = off_e;
    hi    = off_e;
    if (cur.op != OP_LINE) begin
      if (cur.dir_x[VAL_W-1]) begin
        lo = lo + dx_e;
      end else begin
        hi = hi + dx_e;
      end
    end
    if (cur.op == OP_SWEEP2) begin
      if (cur.dir_y[VAL_W-1]) begin
        lo = lo + dy_e;
      end else begin
        hi = hi + dy_e;
      end
    end
    case (cur.op)
      OP_LINE:   d_sel = cur.dir_x;
      OP_SWEEP1: d_sel = cur.dir_y;
      default:   d_sel = cur.dir_z;
    endcase
    case (cur.axis)
      AXIS_X:  size_e = {{(NUM_W-SIZE_W){1'b0}}, size_x};
      AXIS_Y:  size_e = {{(NUM_W-SIZE_W){1'b0}}, size_y};
      default: size_e = {{(NUM_W-SIZE_W){1'b0}}, size_z};
    endcase
    kill = hi < 0 || lo > size_e ||
           (cur.op == OP_LINE &&
            ((cur.axis_offset == '0 && cur.lower_closed) ||
             (off_e == size_e && cur.upper_closed)));
    // Entering the slab uses the near boundary for a positive direction.
    qf = d_r[VAL_W-1] ? quot : qa;
    qt = d_r[VAL_W-1] ? qa : quot;
  end

  assign stat.skip   = cur.op == OP_NONE || cur.axis == AXIS_NONE;
  assign stat.dead   = query_dead;
  assign stat.d_zero = d_sel == '0;
  assign stat.last   = cur.axis == AXIS_Z;

  always_ff @(posedge clk) begin
    if (rst) begin
      size_x <= '0;
      size_y <= '0;
      size_z <= '0;
    end else if (cfg_wr_en) begin
      case (cfg_index)
        REG_SIZE_X: size_x <= cfg_data;
        REG_SIZE_Y: size_y <= cfg_data;
        REG_SIZE_Z: size_z <= cfg_data;
        default:    ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      running_from <= '0;
      running_to   <= '0;
      query_dead   <= 1'b0;
    end else begin
      if (cmd.load && item_in.op != OP_NONE && item_in.axis == AXIS_X) begin
        running_from <= item_in.init_from;
        running_to   <= item_in.init_to;
        query_dead   <= 1'b0;
      end
      if (cmd.prep && !query_dead && d_sel == '0 && kill) begin
        query_dead   <= 1'b1;
        running_from <= '0;
        running_to   <= '0;
      end
      if (cmd.update) begin
        if (qf > running_from) begin
          running_from <= qf;
        end
        if (qt < running_to) begin
          running_to <= qt;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      cur <= item_in;
    end
    if (cmd.prep) begin
      num_a <= NUM_W'(-hi);
      num_b <= NUM_W'(size_e - lo);
      d_r   <= d_sel;
    end
    if (cmd.cap_a) begin
      qa <= quot;
    end
    if (cmd.emit) begin
      if (query_dead) begin
        res.hit         <= 1'b0;
        res.from_factor <= '0;
        res.to_factor   <= '0;
      end else begin
        res.hit         <= !(running_from > running_to);
        res.from_factor <= running_from;
        res.to_factor   <= running_to;
      end
    end
  end

endmodule

/* hdl/sbsc_ctrl.sv */
module sbsc_ctrl (
  input  logic                clk,
  input  logic                rst,
  input  logic                item_valid,
  output logic                item_ready,
  output logic                result_valid,
  input  logic                result_ready,
  input  sbsc_pkg::dp_stat_t  stat,
  output sbsc_pkg::ctrl_cmd_t cmd
);
  import sbsc_pkg::*;

  typedef enum logic [7:0] {
    S_IDLE = 8'b0000_0001,
    S_PREP = 8'b0000_0010,
    S_STA  = 8'b0000_0100,
    S_DIVA = 8'b0000_1000,
    S_STB  = 8'b0001_0000,
    S_DIVB = 8'b0010_0000,
    S_UPD  = 8'b0100_0000,
    S_EMIT = 8'b1000_0000
  } state_t;

  state_t state;
  state_t state_next;
  logic   result_valid_next;

  always_comb begin
    state_next = state;
    cmd        = '0;
    item_ready = 1'b0;
    case (state)
      S_IDLE: begin
        item_ready = 1'b1;
        if (item_valid) begin
          cmd.load   = 1'b1;
          state_next = S_PREP;
        end
      end
      S_PREP: begin
        if (stat.skip) begin
          state_next = S_IDLE;
        end else begin
          cmd.prep = 1'b1;
          if (stat.dead || stat.d_zero) begin
            state_next = stat.last ? S_EMIT : S_IDLE;
          end else begin
            state_next = S_STA;
          end
        end
      end
      S_STA: begin
        cmd.div_start = 1'b1;
        state_next    = S_DIVA;
      end
      S_DIVA: begin
        if (stat.div_done) begin
          cmd.cap_a  = 1'b1;
          state_next = S_STB;
        end
      end
      S_STB: begin
        cmd.div_start = 1'b1;
        cmd.div_sel_b = 1'b1;
        state_next    = S_DIVB;
      end
      S_DIVB: begin
        if (stat.div_done) begin
          state_next = S_UPD;
        end
      end
      S_UPD: begin
        cmd.update = 1'b1;
        state_next = stat.last ? S_EMIT : S_IDLE;
      end
      S_EMIT: begin
        if (!result_valid || result_ready) begin
          cmd.emit   = 1'b1;
          state_next = S_IDLE;
        end
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

  always_comb begin
    if (cmd.emit) begin
      result_valid_next = 1'b1;
    end else if (result_ready) begin
      result_valid_next = 1'b0;
    end else begin
      result_valid_next = result_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state        <= S_IDLE;
      result_valid <= 1'b0;
    end else begin
      state        <= state_next;
      result_valid <= result_valid_next;
    end
  end

endmodule

/* hdl/swept_box_slab_clip.sv */
// An item with a nonzero moving direction runs the single bit-serial divider twice;
// the next item is taken only once the controller is back in its idle state.
// A zero direction, a killed query or an unused code skips the divider. The axis-2
// item passes through an extra state to load the result register.
// Reset (rst, synchronous, active high) clears the box sizes, the running interval,
// the dead flag, the controller state and the result valid flag.
module swept_box_slab_clip #(
  parameter int FRAC_BITS = sbsc_pkg::FRAC_BITS_DEF
) (
  input  logic                            clk,
  input  logic                            rst,
  input  logic                            cfg_wr_en,
  input  logic [sbsc_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [sbsc_pkg::CFG_DATA_W-1:0] cfg_data,
  sbsc_item_if.sink                       item,
  sbsc_result_if.source                   result
);
  import sbsc_pkg::*;

  // The controller sequences each item: latch, form the two boundary
  // numerators, divide each by the moving direction, then narrow the
  // running interval; a zero direction or a killed query skips the divisions.
  // The datapath holds the box sizes, the interval, the result register and the divider.
  ctrl_cmd_t cmd;
  dp_stat_t  stat;
  item_t     item_in;
  result_t   res;

  // Pack the item channel payload for the datapath.
  assign item_in.op           = item.op;
  assign item_in.axis         = item.axis;
  assign item_in.axis_offset  = item.axis_offset;
  assign item_in.dir_x        = item.dir_x;
  assign item_in.dir_y        = item.dir_y;
  assign item_in.dir_z        = item.dir_z;
  assign item_in.init_from    = item.init_from;
  assign item_in.init_to      = item.init_to;
  assign item_in.lower_closed = item.lower_closed;
  assign item_in.upper_closed = item.upper_closed;

  sbsc_ctrl u_ctrl (
    .clk          (clk),
    .rst          (rst),
    .item_valid   (item.valid),
    .item_ready   (item.ready),
    .result_valid (result.valid),
    .result_ready (result.ready),
    .stat         (stat),
    .cmd          (cmd)
  );

  sbsc_dp #(.FRAC_BITS(FRAC_BITS)) u_dp (
    .clk       (clk),
    .rst       (rst),
    .cmd       (cmd),
    .stat      (stat),
    .item_in   (item_in),
    .res       (res),
    .cfg_wr_en (cfg_wr_en),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  // The result register holds a finished query while the next items are
  // already being taken; a new result waits only if it is still unread.
  assign result.hit         = res.hit;
  assign result.from_factor = res.from_factor;
  assign result.to_factor   = res.to_factor;

endmodule

/* bench/tb_top.sv */
module tb_top;
  timeunit 1ns;
  timeprecision 1ps;

  import sbsc_pkg::*;

  // Fixed-point format and handy Q16.16 values.
  localparam int FRAC_BITS = FRAC_BITS_DEF;
  localparam int ONE       = 1 << FRAC_BITS;
  localparam int MIN_Q     = 32'sh8000_0000;
  localparam int MAX_Q     = 32'sh7fff_ffff;

  // One item with a nonzero moving direction runs the divider twice; the last
  // axis also loads the result register.
  localparam int LAT_CYCLES = 2 * (34 + FRAC_BITS) + 10;

  // The watchdog trips after this many cycles without any transfer. The long
  // receiver hold-off below stays well under it.
  localparam int WATCHDOG_CYCLES = 20000;
  localparam int BACKLOG_HOLD    = 1500;

  logic clk = 1'b0;
  logic rst;
  logic                  cfg_wr_en;
  logic [CFG_IDX_W-1:0]  cfg_index;
  logic [CFG_DATA_W-1:0] cfg_data;

  sbsc_item_if   item_ch ();
  sbsc_result_if res_ch ();

  swept_box_slab_clip #(
    .FRAC_BITS (FRAC_BITS)
  ) u_top (
    .clk       (clk),
    .rst       (rst),
    .cfg_wr_en (cfg_wr_en),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .item      (item_ch),
    .result    (res_ch)
  );

  always #6 clk = ~clk;

  // Shadow copy of the box registers and of the running clip interval.
  logic [30:0] box_x, box_y, box_z;
  int          clip_from;
  int          clip_to;
  bit          query_killed;

  // Results predicted at input transfers and still waiting for their
  // output transfer, oldest first.
  result_t clip_expect_q[$];
  result_t head_expect;

  // Run-time knobs shared by the stimulus and the result sink.
  bit src_idle_en;
  bit snk_stall_en;
  bit backlog_hold_req;

  // Bookkeeping for the closing summary.
  int n_err;
  int n_items_in;
  int n_results;
  int n_hits;
  int n_killed;
  int n_sat_quot;
  int n_settings;
  int stuck_cycles;

  initial begin
    box_x        = '0;
    box_y        = '0;
    box_z        = '0;
    clip_from    = 0;
    clip_to      = 0;
    query_killed = 1'b0;
  end

  // ---------------------------------------------------------------------------
  // Clip predictor.
  // ---------------------------------------------------------------------------

  // Clamp a wide value into the signed 32-bit range.
  function automatic int to_q32(longint v);
    if (v > longint'(MAX_Q)) return MAX_Q;
    if (v < longint'(MIN_Q)) return MIN_Q;
    return int'(v);
  endfunction

  // Fixed-point quotient num/den in Q16.16. SystemVerilog integer division
  // truncates toward zero, as the block does; out-of-range results clamp.
  function automatic int sat_quot(longint num, longint den);
    longint q;
    q = (num * (longint'(1) <<< FRAC_BITS)) / den;
    if (q > longint'(MAX_Q) || q < longint'(MIN_Q)) n_sat_quot++;
    return to_q32(q);
  endfunction

  // Advance the shadow interval by one accepted item and queue the result
  // that the last axis of a query produces.
  task automatic predict_clip(input item_t it);
    longint  off, dx, dy, dz, mv, box, lo, hi;
    int      qa, qb, qf, qt;
    bit      outside;
    result_t r;
    // Unused op or axis codes are dropped by the block without a trace.
    if (it.op == OP_NONE || it.axis == AXIS_NONE) return;
    off = longint'($signed(it.axis_offset));
    dx  = longint'($signed(it.dir_x));
    dy  = longint'($signed(it.dir_y));
    dz  = longint'($signed(it.dir_z));
    box = (it.axis == AXIS_X) ? longint'(box_x) :
          (it.axis == AXIS_Y) ? longint'(box_y) : longint'(box_z);
    // The first axis opens a new query with a fresh interval.
    if (it.axis == AXIS_X) begin
      clip_from    = $signed(it.init_from);
      clip_to      = $signed(it.init_to);
      query_killed = 1'b0;
    end
    if (!query_killed) begin
      // Extent of the swept shape on this axis.
      lo = off;
      hi = off;
      if (it.op != OP_LINE) begin
        if (dx < 0) lo += dx;
        else hi += dx;
      end
      if (it.op == OP_SWEEP2) begin
        if (dy < 0) lo += dy;
        else hi += dy;
      end
      mv = (it.op == OP_LINE) ? dx : (it.op == OP_SWEEP1) ? dy : dz;
      if (mv != 0) begin
        qa = sat_quot(-hi, mv);
        qb = sat_quot(box - lo, mv);
        qf = (mv > 0) ? qa : qb;
        qt = (mv > 0) ? qb : qa;
        if (qf > clip_from) clip_from = qf;
        if (qt < clip_to) clip_to = qt;
      end else begin
        // A shape that never moves on this axis must already sit in the slab.
        // Only the plain line honors the closed-boundary flags.
        outside = (hi < 0) || (lo > box);
        if (it.op == OP_LINE && ((off == 0 && it.lower_closed) ||
                                 (off == box && it.upper_closed)))
          outside = 1'b1;
        if (outside) begin
          query_killed = 1'b1;
          clip_from    = 0;
          clip_to      = 0;
        end
      end
    end
    if (it.axis != AXIS_Z) return;
    if (query_killed) begin
      r.hit         = 1'b0;
      r.from_factor = '0;
      r.to_factor   = '0;
      n_killed++;
    end else begin
      r.hit         = (clip_from <= clip_to);
      r.from_factor = clip_from;
      r.to_factor   = clip_to;
    end
    clip_expect_q.push_back(r);
  endtask

  // ---------------------------------------------------------------------------
  // Stimulus helpers.
  // ---------------------------------------------------------------------------

  function automatic item_t mk_item(logic [1:0] op, logic [1:0] axis, int off,
                                    int dx, int dy, int dz, int f0, int t0,
                                    bit lc, bit uc);
    item_t it;
    it.op           = op;
    it.axis         = axis;
    it.axis_offset  = off;
    it.dir_x        = dx;
    it.dir_y        = dy;
    it.dir_z        = dz;
    it.init_from    = f0;
    it.init_to      = t0;
    it.lower_closed = lc;
    it.upper_closed = uc;
    return it;
  endfunction

  // Direction components: zero often enough to exercise the parked-shape
  // checks, tiny and extreme values to drive the quotient into saturation.
  function automatic int rand_dir();
    case ($urandom_range(0, 9))
      0, 1: return 0;
      2: case ($urandom_range(0, 3))
           0: return 1;
           1: return -1;
           2: return MIN_Q;
           default: return MAX_Q;
         endcase
      3: return $urandom;
      default: return int'($urandom_range(0, 16 * ONE)) - 8 * ONE;
    endcase
  endfunction

  // Offsets mostly around the slab, with the exact boundaries picked on
  // purpose so that the closed-boundary flags matter.
  function automatic int coord_near(logic [30:0] box);
    longint span;
    case ($urandom_range(0, 11))
      0: return 0;
      1: return int'(box);
      2: return -1;
      3: return to_q32(longint'(box) + 1);
      4: return $urandom;
      default: begin
        span = longint'(box) + 2 * ONE;
        return to_q32(span * longint'($urandom_range(0, 1000)) / 500 - span / 2);
      end
    endcase
  endfunction

  function automatic item_t rand_item(logic [1:0] op, logic [1:0] axis);
    item_t       it;
    logic [30:0] box;
    box             = (axis == AXIS_Y) ? box_y : (axis == AXIS_Z) ? box_z : box_x;
    it.op           = op;
    it.axis         = axis;
    it.axis_offset  = coord_near(box);
    it.dir_x        = rand_dir();
    it.dir_y        = rand_dir();
    it.dir_z        = rand_dir();
    case ($urandom_range(0, 3))
      0: begin it.init_from = MIN_Q; it.init_to = MAX_Q; end
      1: begin it.init_from = 0; it.init_to = ONE; end
      2: begin it.init_from = $urandom; it.init_to = $urandom; end
      default: begin it.init_from = -ONE; it.init_to = 32 * ONE; end
    endcase
    it.lower_closed = 1'($urandom_range(0, 1));
    it.upper_closed = 1'($urandom_range(0, 1));
    return it;
  endfunction

  // Offer one item and wait for its transfer. Valid is left high afterwards
  // so that back-to-back items never lower and raise it in the same step;
  // any caller that lets time pass without a new item parks the source.
  task automatic send_item(input item_t it);
    int gap;
    if (src_idle_en && $urandom_range(0, 5) == 0) begin
      gap = $urandom_range(1, 16);
      item_ch.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    item_ch.valid        <= 1'b1;
    item_ch.op           <= it.op;
    item_ch.axis         <= it.axis;
    item_ch.axis_offset  <= it.axis_offset;
    item_ch.dir_x        <= it.dir_x;
    item_ch.dir_y        <= it.dir_y;
    item_ch.dir_z        <= it.dir_z;
    item_ch.init_from    <= it.init_from;
    item_ch.init_to      <= it.init_to;
    item_ch.lower_closed <= it.lower_closed;
    item_ch.upper_closed <= it.upper_closed;
    do @(posedge clk); while (item_ch.ready !== 1'b1);
    n_items_in++;
    predict_clip(it);
  endtask

  // Mostly well-formed three-axis queries with random content; now and then
  // a broken sequence of one to three items with any op and axis code.
  task automatic send_random_query();
    logic [1:0] op;
    int         n;
    if ($urandom_range(0, 9) == 0) begin
      n = $urandom_range(1, 3);
      repeat (n) send_item(rand_item(2'($urandom_range(0, 3)), 2'($urandom_range(0, 3))));
    end else begin
      op = 2'($urandom_range(0, 2));
      send_item(rand_item(op, AXIS_X));
      send_item(rand_item(op, AXIS_Y));
      send_item(rand_item(op, AXIS_Z));
    end
  endtask

  // Drop valid and wait until every predicted result has been transferred.
  task automatic park_source();
    item_ch.valid <= 1'b0;
    do @(posedge clk); while (clip_expect_q.size() != 0);
  endtask

  // A trailing axis-0 or axis-1 item has no result to wait for, so the block
  // may still be dividing; give it a full item time before touching registers.
  task automatic settle_block();
    park_source();
    repeat (LAT_CYCLES + 16) @(posedge clk);
  endtask

  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx,
                           input logic [CFG_DATA_W-1:0] val);
    cfg_wr_en <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= val;
    @(posedge clk);
  endtask

  task automatic set_box(input logic [30:0] sx, input logic [30:0] sy,
                         input logic [30:0] sz);
    settle_block();
    write_reg(REG_SIZE_X, sx);
    write_reg(REG_SIZE_Y, sy);
    write_reg(REG_SIZE_Z, sz);
    cfg_wr_en <= 1'b0;
    box_x = sx;
    box_y = sy;
    box_z = sz;
    n_settings++;
    @(posedge clk);
  endtask

  // ---------------------------------------------------------------------------
  // Tests.
  // ---------------------------------------------------------------------------

  // Hand-picked queries: each op, every parked-shape kill, the flags that only
  // the line honors, ignored codes, a query with no opening axis, and the
  // extremes of the value range that saturate the quotient.
  task automatic test_directed_cases();
    set_box(31'(4 * ONE), 31'(2 * ONE), 31'(8 * ONE));
    // Line query; the last axis is parked exactly on the closed upper face.
    send_item(mk_item(OP_LINE, AXIS_X, -ONE, ONE, 0, 0, MIN_Q, MAX_Q, 1'b0, 1'b0));
    send_item(mk_item(OP_LINE, AXIS_Y, ONE, ONE / 2, 0, 0, 0, 0, 1'b1, 1'b0));
    send_item(mk_item(OP_LINE, AXIS_Z, 8 * ONE, 0, 0, 0, 0, 0, 1'b0, 1'b1));
    // Swept edge; a parked shape on the face survives because the flags are
    // ignored for this op.
    send_item(mk_item(OP_SWEEP1, AXIS_X, ONE / 2, -ONE, 2 * ONE, 0, 0, ONE, 1'b0, 1'b0));
    send_item(mk_item(OP_SWEEP1, AXIS_Y, 3 * ONE, ONE / 4, -ONE, 0, 0, 0, 1'b0, 1'b0));
    send_item(mk_item(OP_SWEEP1, AXIS_Z, 8 * ONE, 0, 0, 0, 0, 0, 1'b1, 1'b1));
    // Swept parallelogram.
    send_item(mk_item(OP_SWEEP2, AXIS_X, ONE, ONE, -2 * ONE, ONE / 2, MIN_Q, MAX_Q,
                      1'b0, 1'b0));
    send_item(mk_item(OP_SWEEP2, AXIS_Y, 0, -ONE / 2, ONE / 2, -ONE, 0, 0, 1'b0, 1'b0));
    send_item(mk_item(OP_SWEEP2, AXIS_Z, 4 * ONE, ONE, ONE, 3 * ONE, 0, 0, 1'b0, 1'b0));
    // Unused op and axis codes must leave no mark.
    send_item(mk_item(OP_NONE, AXIS_X, 0, ONE, ONE, ONE, 0, 0, 1'b1, 1'b1));
    send_item(mk_item(OP_LINE, AXIS_NONE, 0, ONE, ONE, ONE, 0, 0, 1'b1, 1'b1));
    // No opening axis: these narrow whatever interval is left over.
    send_item(mk_item(OP_LINE, AXIS_Y, ONE / 2, -ONE / 4, 0, 0, 0, 0, 1'b0, 1'b0));
    send_item(mk_item(OP_SWEEP1, AXIS_Z, 2 * ONE, ONE, -ONE / 2, 0, 0, 0, 1'b0, 1'b0));
    // Parked entirely below the slab; the later axes must change nothing.
    send_item(mk_item(OP_SWEEP2, AXIS_X, -5 * ONE, ONE, ONE, 0, MIN_Q, MAX_Q,
                      1'b0, 1'b0));
    send_item(mk_item(OP_LINE, AXIS_Y, ONE, ONE, 0, 0, 0, 0, 1'b0, 1'b0));
    send_item(mk_item(OP_LINE, AXIS_Z, ONE, -ONE, 0, 0, 0, 0, 1'b0, 1'b0));
    // Line parked on the closed lower face.
    send_item(mk_item(OP_LINE, AXIS_X, 0, 0, ONE, ONE, 0, ONE, 1'b1, 1'b0));
    send_item(mk_item(OP_LINE, AXIS_Y, ONE, ONE, 0, 0, 0, 0, 1'b0, 1'b0));
    send_item(mk_item(OP_LINE, AXIS_Z, ONE, ONE, 0, 0, 0, 0, 1'b0, 1'b0));
    // Parked entirely above the slab.
    send_item(mk_item(OP_SWEEP1, AXIS_X, 6 * ONE, -ONE, 0, 0, MIN_Q, MAX_Q, 1'b0, 1'b0));
    send_item(mk_item(OP_SWEEP1, AXIS_Y, ONE, ONE, ONE, 0, 0, 0, 1'b0, 1'b0));
    send_item(mk_item(OP_SWEEP1, AXIS_Z, ONE, ONE, ONE, 0, 0, 0, 1'b0, 1'b0));
    // Extreme offsets and directions; the first and last items saturate both quotients.
    send_item(mk_item(OP_LINE, AXIS_X, MIN_Q, 1, MAX_Q, MIN_Q, MIN_Q, MAX_Q, 1'b1, 1'b1));
    send_item(mk_item(OP_LINE, AXIS_Y, MAX_Q, MIN_Q, 1, -1, 0, 0, 1'b1, 1'b1));
    send_item(mk_item(OP_SWEEP2, AXIS_Z, MIN_Q, MIN_Q, MIN_Q, -1, 0, 0, 1'b1, 1'b1));
  endtask

  // Random queries under several box settings, the empty box and the largest
  // box among them, with idling on both sides.
  task automatic test_size_sweep();
    for (int s = 0; s < 5; s++) begin
      case (s)
        0: set_box('0, '0, '0);
        1: set_box('1, '1, '1);
        2: set_box(31'($urandom_range(ONE, 64 * ONE)), 31'($urandom_range(ONE, 64 * ONE)),
                   31'($urandom_range(ONE, 64 * ONE)));
        3: set_box(31'($urandom_range(0, MAX_Q)), 31'($urandom_range(0, MAX_Q)),
                   31'($urandom_range(0, MAX_Q)));
        default: set_box(31'd1, '1, 31'(4 * ONE));
      endcase
      repeat (60) send_random_query();
    end
  endtask

  // The receiver holds off for a long stretch while the sender keeps offering
  // items, so the result register fills and the input stalls behind it.
  task automatic test_result_backlog();
    set_box(31'(16 * ONE), 31'(16 * ONE), 31'(16 * ONE));
    src_idle_en      = 1'b0;
    backlog_hold_req = 1'b1;
    repeat (10) send_random_query();
    src_idle_en = 1'b1;
  endtask

  // The sender stops mid-stream until every result has come back, then goes on.
  task automatic test_drain_pause();
    repeat (10) send_random_query();
    park_source();
    repeat (10) send_random_query();
  endtask

  // Back-to-back traffic with no idling on either side.
  task automatic test_steady_tail();
    set_box(31'($urandom_range(ONE, 32 * ONE)), 31'($urandom_range(ONE, 32 * ONE)),
            31'($urandom_range(ONE, 32 * ONE)));
    src_idle_en  = 1'b0;
    snk_stall_en = 1'b0;
    repeat (60) send_random_query();
  endtask

  // ---------------------------------------------------------------------------
  // Result sink: random stall bursts, long stretches of steady ready, and the
  // long hold-off that the backlog test requests.
  // ---------------------------------------------------------------------------
  initial begin : result_sink
    int n;
    res_ch.ready <= 1'b0;
    @(posedge clk);
    forever begin
      if (backlog_hold_req) begin
        res_ch.ready <= 1'b0;
        repeat (BACKLOG_HOLD) @(posedge clk);
        backlog_hold_req = 1'b0;
      end else if (snk_stall_en && $urandom_range(0, 3) == 0) begin
        n = $urandom_range(1, 16);
        res_ch.ready <= 1'b0;
        repeat (n) @(posedge clk);
      end else begin
        n = $urandom_range(1, 24);
        res_ch.ready <= 1'b1;
        repeat (n) @(posedge clk);
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Result checker: every output transfer is matched against the oldest
  // prediction, field by field.
  // ---------------------------------------------------------------------------
  always @(posedge clk) begin
    if (!rst && res_ch.valid === 1'b1 && res_ch.ready === 1'b1) begin
      if (clip_expect_q.size() == 0) begin
        $error("unexpected result transfer: hit=%0b from_factor=%0d to_factor=%0d",
               res_ch.hit, res_ch.from_factor, res_ch.to_factor);
        n_err++;
      end else begin
        head_expect = clip_expect_q.pop_front();
        n_results++;
        if (head_expect.hit) n_hits++;
        if (res_ch.hit !== head_expect.hit) begin
          $error("hit: expected %0b, actual %0b", head_expect.hit, res_ch.hit);
          n_err++;
        end
        if (res_ch.from_factor !== head_expect.from_factor) begin
          $error("from_factor: expected %0d, actual %0d",
                 head_expect.from_factor, res_ch.from_factor);
          n_err++;
        end
        if (res_ch.to_factor !== head_expect.to_factor) begin
          $error("to_factor: expected %0d, actual %0d",
                 head_expect.to_factor, res_ch.to_factor);
          n_err++;
        end
      end
    end
  end

  // Watchdog: a correct block always makes some transfer within a bounded
  // number of cycles, even behind the long receiver hold-off.
  always @(posedge clk) begin
    if (rst || (item_ch.valid && item_ch.ready) || (res_ch.valid && res_ch.ready))
      stuck_cycles = 0;
    else
      stuck_cycles++;
    if (stuck_cycles >= WATCHDOG_CYCLES) begin
      $display("timeout: no transfer for %0d cycles", WATCHDOG_CYCLES);
      $display("end of test: mismatches");
      $finish;
    end
  end

  // ---------------------------------------------------------------------------
  // Main sequence.
  // ---------------------------------------------------------------------------
  initial begin : main_seq
    // Every block input is known from the first step.
    rst                  <= 1'b1;
    cfg_wr_en            <= 1'b0;
    cfg_index            <= '0;
    cfg_data             <= '0;
    item_ch.valid        <= 1'b0;
    item_ch.op           <= OP_LINE;
    item_ch.axis         <= AXIS_X;
    item_ch.axis_offset  <= '0;
    item_ch.dir_x        <= '0;
    item_ch.dir_y        <= '0;
    item_ch.dir_z        <= '0;
    item_ch.init_from    <= '0;
    item_ch.init_to      <= '0;
    item_ch.lower_closed <= 1'b0;
    item_ch.upper_closed <= 1'b0;
    src_idle_en      = 1'b1;
    snk_stall_en     = 1'b1;
    backlog_hold_req = 1'b0;
    repeat (10) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    test_directed_cases();
    test_size_sweep();
    test_result_backlog();
    test_drain_pause();
    test_steady_tail();

    // Let the last results come back, then allow one more item time in case
    // the final item produced nothing.
    settle_block();
    if (clip_expect_q.size() != 0) begin
      $error("%0d predicted results never arrived", clip_expect_q.size());
      n_err++;
    end

    $display("Sent %0d items over %0d box settings; checked %0d clip results.",
             n_items_in, n_settings, n_results);
    $display("Of those, %0d hit, %0d came from killed queries; %0d quotients saturated.",
             n_hits, n_killed, n_sat_quot);
    if (n_err == 0)
      $display("end of test: clean");
    else
      $display("end of test: mismatches");
    $finish;
  end

endmodule
